// File: design/htsed_pkg.sv
package htsed_pkg;

    localparam int NAME_MAX    = 8;
    localparam int LEN_W       = $clog2(NAME_MAX + 1);
    localparam int IDX_W       = $clog2(NAME_MAX);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int REF_CHARS   = 6;
    localparam int LATIN_COUNT = 64;
    localparam int SPECIAL_COUNT = 4;

    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_AMP   = 8'h26;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] LATIN_BASE = 8'hC0;

    typedef enum logic [1:0] {
        MODE_TEXT   = 2'd0,
        MODE_TAG    = 2'd1,
        MODE_ENTITY = 2'd2
    } mode_t;

    typedef logic [NAME_MAX-1:0][7:0] name_t;
    typedef logic [LEN_W-1:0]         len_t;
    typedef logic [8*REF_CHARS-1:0]   ref_name_t;

    // One queued word: a plain byte to pass, or an entity to resolve
    typedef struct packed {
        logic  is_entity;
        logic  [7:0] value;
        logic  has_digit;
        logic  overflow;
        len_t  length;
        name_t name;
    } cmd_t;

    localparam ref_name_t SPECIAL_NAMES [SPECIAL_COUNT] = '{
        "nbsp", "amp", "lt", "gt"
    };
    localparam logic [7:0] SPECIAL_CHARS [SPECIAL_COUNT] = '{
        CHAR_SPACE, CHAR_AMP, CHAR_LT, CHAR_GT
    };

    localparam ref_name_t LATIN_NAMES [LATIN_COUNT] = '{
        "Agrave", "Aacute", "Acirc", "Atilde", "Auml", "Aring", "AElig", "Ccedil",
        "Egrave", "Eacute", "Ecirc", "Euml", "Igrave", "Iacute", "Icirc", "Iuml",
        "ETH", "Ntilde", "Ograve", "Oacute", "Ocirc", "Otilde", "Ouml", "cross",
        "Oslash", "Ugrave", "Uacute", "Ucirc", "Uuml", "Yacute", "THORN", "szlig",
        "agrave", "aacute", "acirc", "atilde", "auml", "aring", "aelig", "ccedil",
        "egrave", "eacute", "ecirc", "euml", "igrave", "iacute", "icirc", "iuml",
        "eth", "ntilde", "ograve", "oacute", "ocirc", "otilde", "ouml", "divis",
        "oslash", "ugrave", "uacute", "ucirc", "uuml", "yacute", "thorn", "yuml"
    };

    // Literals sit right-justified: first character in the highest used byte
    function automatic logic name_match(input cmd_t cmd, input ref_name_t ref_str);
        int   ref_len;
        logic hit;
        ref_len = 0;
        for (int k = 0; k < REF_CHARS; k++) begin
            if (ref_str[8*k +: 8] != 8'h00) begin
                ref_len = ref_len + 1;
            end
        end
        hit = !cmd.overflow && (cmd.length == LEN_W'(ref_len)) && (ref_len <= NAME_MAX);
        for (int j = 0; j < REF_CHARS; j++) begin
            if (j < ref_len && j < NAME_MAX) begin
                if (cmd.name[j] != ref_str[8*(ref_len-1-j) +: 8]) begin
                    hit = 1'b0;
                end
            end
        end
        return hit;
    endfunction

    function automatic logic [7:0] resolve_entity(input cmd_t cmd);
        logic [7:0] result;
        logic       found;
        result = CHAR_AMP;
        found  = 1'b0;
        for (int i = 0; i < SPECIAL_COUNT; i++) begin
            if (!found && name_match(cmd, SPECIAL_NAMES[i])) begin
                result = SPECIAL_CHARS[i];
                found  = 1'b1;
            end
        end
        for (int i = 0; i < LATIN_COUNT; i++) begin
            if (!found && name_match(cmd, LATIN_NAMES[i])) begin
                result = LATIN_BASE + 8'(i);
                found  = 1'b1;
            end
        end
        if (cmd.length != '0 && cmd.name[0] == CHAR_HASH) begin
            result = cmd.has_digit ? cmd.value : CHAR_HASH;
        end
        return result;
    endfunction

endpackage

// File: design/html_tag_strip_entity_decode_unit.sv
// A byte that gives output reaches m_tdata through its queue entry and then the output register.
// Throughput: one byte per cycle while the queue has room; a two-word queue between the parser and the
// entity resolver lets each side stall on its own, and the output register holds one word.
// Entity names are matched against all known names in parallel in the resolver stage.
// Reset (aresetn low, synchronous): text mode, counters cleared, queue and output emptied.
module html_tag_strip_entity_decode_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [7:0] out_byte
);
    import htsed_pkg::*;

    logic push;
    cmd_t push_cmd;
    logic push_ready;
    logic pop;
    logic pop_valid;
    cmd_t pop_cmd;

    htsed_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_ready  (push_ready),
        .q_push   (push),
        .q_cmd    (push_cmd)
    );

    htsed_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd)
    );

    htsed_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (pop_valid),
        .q_cmd    (pop_cmd),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: design/htsed_front.sv
module htsed_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              q_ready,
    output logic              q_push,
    output htsed_pkg::cmd_t   q_cmd
);
    import htsed_pkg::*;

    mode_t      mode_reg, mode_next;
    name_t      name_reg, name_next;
    len_t       len_reg, len_next;
    logic       ovf_reg, ovf_next;
    logic [7:0] value_reg, value_next;
    logic       digit_reg, digit_next;

    logic       accept;
    logic [7:0] c;
    logic       is_number;
    logic       is_digit;
    logic       has_room;

    assign s_tready  = q_ready;
    assign accept    = s_tvalid && s_tready;
    assign c         = s_tdata;
    assign is_number = (len_reg != '0) && (name_reg[0] == CHAR_HASH);
    assign is_digit  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    assign has_room  = len_reg < LEN_W'(NAME_MAX);

    always_comb begin
        mode_next = mode_reg;
        if (accept) begin
            unique case (mode_reg)
                MODE_TAG: begin
                    if (c == CHAR_GT) mode_next = MODE_TEXT;
                end
                MODE_ENTITY: begin
                    if (c == CHAR_SEMI) mode_next = MODE_TEXT;
                end
                default: begin
                    if (c == CHAR_LT) begin
                        mode_next = MODE_TAG;
                    end else if (c == CHAR_AMP) begin
                        mode_next = MODE_ENTITY;
                    end
                end
            endcase
        end
    end

    always_comb begin
        name_next  = name_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        value_next = value_reg;
        digit_next = digit_reg;
        q_push     = 1'b0;
        q_cmd.is_entity = 1'b0;
        q_cmd.value     = c;
        q_cmd.has_digit = digit_reg;
        q_cmd.overflow  = ovf_reg;
        q_cmd.length    = len_reg;
        q_cmd.name      = name_reg;
        if (accept) begin
            unique case (mode_reg)
                MODE_TAG: begin
                end
                MODE_ENTITY: begin
                    if (c == CHAR_SEMI) begin
                        q_push          = 1'b1;
                        q_cmd.is_entity = 1'b1;
                        q_cmd.value     = value_reg;
                    end else begin
                        if (is_number) begin
                            if (is_digit && !ovf_reg) begin
                                value_next = 8'((value_reg << 3) + (value_reg << 1)
                                                + (c - CHAR_ZERO));
                                digit_next = 1'b1;
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end else if (!has_room) begin
                            ovf_next = 1'b1;
                        end
                        if (has_room) begin
                            name_next[len_reg[IDX_W-1:0]] = c;
                            len_next = LEN_W'(len_reg + 1'b1);
                        end
                    end
                end
                default: begin
                    if (c == CHAR_AMP) begin
                        len_next   = '0;
                        ovf_next   = 1'b0;
                        value_next = '0;
                        digit_next = 1'b0;
                    end else if (c != CHAR_LT) begin
                        q_push = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_TEXT;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
            value_reg <= '0;
            digit_reg <= 1'b0;
        end else begin
            mode_reg  <= mode_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            value_reg <= value_next;
            digit_reg <= digit_next;
        end
    end

    always_ff @(posedge aclk) begin
        name_reg <= name_next;
    end

endmodule

// File: design/htsed_queue.sv
module htsed_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  htsed_pkg::cmd_t push_cmd,
    output logic            push_ready,
    input  logic            pop,
    output logic            pop_valid,
    output htsed_pkg::cmd_t pop_cmd
);
    import htsed_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : QPTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : QPTR_W'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop) begin
            count_next = QCNT_W'(count_reg + 1'b1);
        end else if (do_pop && !do_push) begin
            count_next = QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: design/htsed_back.sv
module htsed_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  htsed_pkg::cmd_t q_cmd,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata
);
    import htsed_pkg::*;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;

    // Advance whenever the output register is empty or its word is taken
    assign q_pop = q_valid && (!out_valid_reg || m_tready);

    always_comb begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        if (q_pop) begin
            out_valid_next = 1'b1;
            out_byte_next  = q_cmd.is_entity ? resolve_entity(q_cmd) : q_cmd.value;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg <= out_byte_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;

endmodule
